### hw/rtl/nfa_es_pkg.sv
// Shared types and constants for the NFA epsilon step engine.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package nfa_es_pkg;

    // Fixed widths of the configuration port and of the shown state set.
    localparam int CFG_DATA_W = 32;
    localparam int OUT_SET_W  = 32;

    // Kinds of input transaction.
    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_STEP    = 2'd2,
        KIND_IGNORE  = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_SYMBOL  = 3'd1,
        ST_NO_STATE    = 3'd2,
        ST_DUPLICATE   = 3'd3,
        ST_ALPHA_EMPTY = 3'd4
    } stat_code_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_STATE   = 2'd0,
        CFG_STATE_COUNT   = 2'd1,
        CFG_ALPHABET_SIZE = 2'd2,
        CFG_ACCEPT_MASK   = 2'd3
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_CHK,
        S_ADD_UPD,
        S_STEP_INIT,
        S_CL_WALK,
        S_CL_DRAIN,
        S_CL_CHECK,
        S_MV_WALK,
        S_MV_DRAIN,
        S_MV_DONE,
        S_FINISH
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       clr_step;
        logic       set_status;
        stat_code_t status_code;
        logic       restart;
        logic       step_init;
        logic       walk_start;
        logic       issue;
        logic       move_mode;
        logic       move_init;
        logic       work_from_next;
        logic       commit;
        logic       add_wr;
        logic       out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clear_last;
        stat_code_t add_code;
        logic       dup;
        logic       alpha_empty;
        logic       sym_in_range;
        logic       row_last;
        logic       changed;
    } dp_stat_t;

endpackage

### hw/rtl/nfa_epsilon_step_engine.sv
// Top level of the NFA epsilon step engine: controller plus datapath.
// Depends on nfa_es_pkg, nfa_es_ctrl and nfa_es_dp.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  kind, from_state, to_state, symbol, is_epsilon
//   out      output     out_valid/out_stall  accepted, active_states, status
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// After reset a clearing pass zeroes the transition stores, one entry per cycle,
// through all NUM_STATES * NUM_SYMBOLS entries; in_stall stays high during it.
// One transaction is in work at a time. Restart, ignored kinds and a step with an
// empty alphabet go straight to the finish state; an add passes a check state and,
// if the checks pass, an update state. Any other symbol step runs a closure, a
// symbol move and a second closure, each closure sweeping all rows (at least once)
// until its set stops growing, one row per cycle on each store's single read port.
// A finished result waits in the output register while the next item is taken;
// while that result is stalled, the next one waits in the finish state.
`timescale 1ns / 1ps

module nfa_epsilon_step_engine #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [4:0]  from_state,
    input  logic [4:0]  to_state,
    input  logic [3:0]  symbol,
    input  logic        is_epsilon,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [31:0] active_states,
    output logic [2:0]  status
);
    import nfa_es_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing of each transaction.
    nfa_es_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Stores, sets and result registers.
    nfa_es_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .from_state    (from_state),
        .to_state      (to_state),
        .symbol        (symbol),
        .is_epsilon    (is_epsilon),
        .cmd           (cmd),
        .stat          (stat),
        .accepted      (accepted),
        .active_states (active_states),
        .status        (status)
    );

endmodule

### hw/rtl/nfa_es_ctrl.sv
// Controller state machine of the NFA epsilon step engine.
// Depends on nfa_es_pkg; drives the datapath through dp_cmd_t commands.
`timescale 1ns / 1ps

module nfa_es_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           kind,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  nfa_es_pkg::dp_stat_t stat,
    output nfa_es_pkg::dp_cmd_t  cmd
);
    import nfa_es_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       second_reg;
    logic       second_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output slot can take a new result when empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // State, closure phase and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.status_code = ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (kind_t'(kind))
                        KIND_ADD:
                            state_next = S_ADD_CHK;
                        KIND_RESTART:
                        begin
                            cmd.restart = 1'b1;
                            state_next  = S_FINISH;
                        end
                        KIND_STEP:
                        begin
                            if (stat.alpha_empty)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = ST_ALPHA_EMPTY;
                                state_next      = S_FINISH;
                            end
                            else
                                state_next = S_STEP_INIT;
                        end
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end
            S_ADD_CHK:
            begin
                // The target row is read during this cycle; it is used when the checks pass.
                if (stat.add_code != ST_OK)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = stat.add_code;
                    state_next      = S_FINISH;
                end
                else
                    state_next = S_ADD_UPD;
            end
            S_ADD_UPD:
            begin
                if (stat.dup)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_DUPLICATE;
                end
                else
                    cmd.add_wr = 1'b1;
                state_next = S_FINISH;
            end
            S_STEP_INIT:
            begin
                cmd.step_init  = 1'b1;
                cmd.walk_start = 1'b1;
                second_next    = 1'b0;
                state_next     = S_CL_WALK;
            end
            S_CL_WALK:
            begin
                cmd.issue = 1'b1;
                if (stat.row_last)
                    state_next = S_CL_DRAIN;
            end
            S_CL_DRAIN:
                state_next = S_CL_CHECK;
            S_CL_CHECK:
            begin
                // Another sweep while the set still grows.
                if (stat.changed)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_CL_WALK;
                end
                else if (second_reg)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.move_init  = 1'b1;
                    cmd.walk_start = 1'b1;
                    state_next     = stat.sym_in_range ? S_MV_WALK : S_MV_DONE;
                end
            end
            S_MV_WALK:
            begin
                cmd.issue     = 1'b1;
                cmd.move_mode = 1'b1;
                if (stat.row_last)
                    state_next = S_MV_DRAIN;
            end
            S_MV_DRAIN:
                state_next = S_MV_DONE;
            S_MV_DONE:
            begin
                cmd.work_from_next = 1'b1;
                cmd.walk_start     = 1'b1;
                second_next        = 1'b1;
                state_next         = S_CL_WALK;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // A result is only loaded into a free output slot.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an undelivered one");

    // The clearing pass runs to its last entry before items are taken.
    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !stat.clear_last) |=> (state_reg == S_CLEAR))
        else $error("clearing pass left early");

    // An accepted transaction always starts work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted transaction dropped");

endmodule

### hw/rtl/nfa_es_dp.sv
// Datapath of the NFA epsilon step engine: configuration, transition stores,
// state sets, row walker and output registers. Depends on nfa_es_pkg.
`timescale 1ns / 1ps

module nfa_es_dp #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [4:0]           from_state,
    input  logic [4:0]           to_state,
    input  logic [3:0]           symbol,
    input  logic                 is_epsilon,
    input  nfa_es_pkg::dp_cmd_t  cmd,
    output nfa_es_pkg::dp_stat_t stat,
    output logic                 accepted,
    output logic [31:0]          active_states,
    output logic [2:0]           status
);
    import nfa_es_pkg::*;

    localparam int SET_W     = NUM_STATES;
    localparam int ROW_W     = $clog2(NUM_STATES);
    localparam int MEM_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Configuration registers.
    logic [4:0]            start_reg;
    logic [5:0]            count_reg;
    logic [4:0]            alpha_reg;
    logic [CFG_DATA_W-1:0] mask_reg;

    // Latched item fields and status.
    logic [4:0] from_reg;
    logic [4:0] to_reg;
    logic [3:0] sym_reg;
    logic       eps_reg;
    stat_code_t status_reg;

    // State sets and walker.
    logic [SET_W-1:0]  active_reg;
    logic [SET_W-1:0]  work_reg;
    logic [SET_W-1:0]  work_next;
    logic [SET_W-1:0]  nxt_reg;
    logic [SET_W-1:0]  nxt_next;
    logic              changed_reg;
    logic              changed_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  prow_reg;
    logic              pend_reg;
    logic              pmove_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic [MEM_AW-1:0] clr_reg;

    // Transition stores.
    logic [SET_W-1:0]  sym_mem [MEM_DEPTH];
    logic [SET_W-1:0]  eps_mem [NUM_STATES];
    logic [SET_W-1:0]  sym_rd_reg;
    logic [SET_W-1:0]  eps_rd_reg;
    logic [MEM_AW-1:0] sym_raddr;
    logic [ROW_W-1:0]  eps_raddr;
    logic [MEM_AW-1:0] add_addr;
    logic              sym_we;
    logic [MEM_AW-1:0] sym_waddr;
    logic [SET_W-1:0]  sym_wdata;
    logic              eps_we;
    logic [ROW_W-1:0]  eps_waddr;
    logic [SET_W-1:0]  eps_wdata;

    // Output registers.
    logic              accepted_reg;
    logic [OUT_SET_W-1:0] shown_reg;
    logic [2:0]        status_out_reg;

    // Derived item values.
    logic [SET_W-1:0] start_bit;
    logic [SET_W-1:0] to_bit;
    logic             from_ok;
    logic             to_ok;
    logic             sym_bad;
    logic [SET_W-1:0] add_row;
    logic [OUT_SET_W-1:0] shown;

    assign start_bit = (32'(start_reg) < 32'(NUM_STATES)) ? (SET_W'(1) << start_reg) : '0;
    assign to_bit    = SET_W'(1) << to_reg;
    assign from_ok   = ({1'b0, from_reg} < count_reg) && (32'(from_reg) < 32'(NUM_STATES));
    assign to_ok     = ({1'b0, to_reg} < count_reg) && (32'(to_reg) < 32'(NUM_STATES));
    assign sym_bad   = !eps_reg && (({1'b0, sym_reg} >= alpha_reg)
                       || (32'(sym_reg) >= 32'(NUM_SYMBOLS)));
    assign add_addr  = MEM_AW'(32'(from_reg) * NUM_SYMBOLS + 32'(sym_reg));
    assign add_row   = eps_reg ? eps_rd_reg : sym_rd_reg;
    assign shown     = OUT_SET_W'(active_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.clear_last   = (clr_reg == MEM_AW'(MEM_DEPTH - 1));
        if (sym_bad)
            stat.add_code = ST_BAD_SYMBOL;
        else if (!to_ok || !from_ok)
            stat.add_code = ST_NO_STATE;
        else
            stat.add_code = ST_OK;
        stat.dup          = |(add_row & to_bit);
        stat.alpha_empty  = (alpha_reg == 5'd0);
        stat.sym_in_range = (32'(sym_reg) < 32'(NUM_SYMBOLS));
        stat.row_last     = (row_reg == ROW_W'(NUM_STATES - 1));
        stat.changed      = changed_reg;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 5'd0;
            count_reg <= 6'd32;
            alpha_reg <= 5'd16;
            mask_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_STATE:   start_reg <= cfg_data[4:0];
                CFG_STATE_COUNT:   count_reg <= cfg_data[5:0];
                CFG_ALPHABET_SIZE: alpha_reg <= cfg_data[4:0];
                CFG_ACCEPT_MASK:   mask_reg  <= cfg_data;
                default:           mask_reg  <= mask_reg;
            endcase
        end
    end

    // Item fields and status code.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            from_reg <= from_state;
            to_reg   <= to_state;
            sym_reg  <= symbol;
            eps_reg  <= is_epsilon;
        end
        if (cmd.set_status)
            status_reg <= cmd.status_code;
        else if (cmd.load_item)
            status_reg <= ST_OK;
    end

    // Store addressing: the walker reads row by row, an add reads its target row.
    always_comb
    begin
        sym_raddr = cmd.issue ? addr_reg : add_addr;
        eps_raddr = cmd.issue ? row_reg : ROW_W'(from_reg);
        sym_we    = 1'b0;
        sym_waddr = add_addr;
        sym_wdata = sym_rd_reg | to_bit;
        eps_we    = 1'b0;
        eps_waddr = ROW_W'(from_reg);
        eps_wdata = eps_rd_reg | to_bit;
        if (cmd.clr_step)
        begin
            sym_we    = 1'b1;
            sym_waddr = clr_reg;
            sym_wdata = '0;
            eps_we    = (clr_reg < MEM_AW'(NUM_STATES));
            eps_waddr = ROW_W'(clr_reg);
            eps_wdata = '0;
        end
        else if (cmd.add_wr)
        begin
            sym_we = !eps_reg;
            eps_we = eps_reg;
        end
    end

    // Symbol transition store.
    always_ff @(posedge clk)
    begin
        if (sym_we)
            sym_mem[sym_waddr] <= sym_wdata;
        sym_rd_reg <= sym_mem[sym_raddr];
    end

    // Epsilon transition store.
    always_ff @(posedge clk)
    begin
        if (eps_we)
            eps_mem[eps_waddr] <= eps_wdata;
        eps_rd_reg <= eps_mem[eps_raddr];
    end

    // Set updates: a row read in the previous cycle is folded in if its state is in the set.
    always_comb
    begin
        work_next    = work_reg;
        nxt_next     = nxt_reg;
        changed_next = changed_reg;
        if (cmd.step_init)
            work_next = (active_reg == '0) ? start_bit : active_reg;
        else if (cmd.work_from_next)
            work_next = nxt_reg;
        else if (pend_reg && !pmove_reg && work_reg[prow_reg])
        begin
            work_next    = work_reg | eps_rd_reg;
            changed_next = changed_reg | (|(eps_rd_reg & ~work_reg));
        end
        if (cmd.move_init)
            nxt_next = '0;
        else if (pend_reg && pmove_reg && work_reg[prow_reg])
            nxt_next = nxt_reg | sym_rd_reg;
        if (cmd.walk_start)
            changed_next = 1'b0;
    end

    // Set registers.
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        nxt_reg     <= nxt_next;
        changed_reg <= changed_next;
    end

    // Active set and walker control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            row_reg    <= '0;
            prow_reg   <= '0;
            pend_reg   <= 1'b0;
            pmove_reg  <= 1'b0;
            addr_reg   <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.restart)
                active_reg <= start_bit;
            else if (cmd.commit)
                active_reg <= work_reg;
            if (cmd.walk_start)
                row_reg <= '0;
            else if (cmd.issue)
                row_reg <= row_reg + ROW_W'(1);
            if (cmd.move_init)
                addr_reg <= MEM_AW'(sym_reg);
            else if (cmd.issue && cmd.move_mode)
                addr_reg <= addr_reg + MEM_AW'(NUM_SYMBOLS);
            if (cmd.clr_step)
                clr_reg <= clr_reg + MEM_AW'(1);
            pend_reg  <= cmd.issue;
            pmove_reg <= cmd.move_mode;
            prow_reg  <= row_reg;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            accepted_reg   <= |(shown & mask_reg);
            shown_reg      <= shown;
            status_out_reg <= status_reg;
        end
    end

    assign accepted      = accepted_reg;
    assign active_states = shown_reg;
    assign status        = status_out_reg;

    // A transition is stored only after all checks pass.
    a_add_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_wr |-> (stat.add_code == ST_OK && !stat.dup))
        else $error("transition stored despite a failed check");

    // No row read is still in flight when the set is committed.
    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !pend_reg)
        else $error("commit with a row still pending");

    // The symbol walk runs only for a symbol that has rows in the store.
    a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.move_mode) |-> stat.sym_in_range)
        else $error("symbol walk outside the store");

endmodule

### sim/nfa_epsilon_step_engine_test.sv
// Self-checking testbench for the NFA epsilon step engine: directed and random transactions.
// It predicts every result with its own copy of the automaton and compares it with the result.
// Depends on nfa_es_pkg and nfa_epsilon_step_engine.
`timescale 1ns / 1ps

module nfa_epsilon_step_engine_test;
    import nfa_es_pkg::*;

    localparam longint TIMEOUT_NS = 500_000_000;
    localparam int     MAX_REPORTS = 10;

    // Expected fields of one result transaction.
    typedef struct packed {
        logic       accepted;
        logic [31:0] states;
        stat_code_t code;
    } nfa_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_START_STATE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = KIND_IGNORE;
    logic [4:0]  from_state = '0;
    logic [4:0]  to_state = '0;
    logic [3:0]  symbol = '0;
    logic        is_epsilon = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [31:0] active_states;
    logic [2:0]  status;

    // Predicted automaton: transition stores, active set and register copies.
    logic [31:0] sym_edges [32][16];
    logic [31:0] eps_edges [32];
    logic [31:0] live_set;
    logic [4:0]  cfg_start;
    logic [5:0]  cfg_states;
    logic [4:0]  cfg_symbols;
    logic [31:0] cfg_accept;

    nfa_outcome_t expected_outcomes [$];
    logic idle_on = 1'b1;
    int   error_count = 0;
    int   results_checked = 0;
    int   adds_sent = 0;
    int   steps_sent = 0;
    int   others_sent = 0;

    nfa_epsilon_step_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .from_state    (from_state),
        .to_state      (to_state),
        .symbol        (symbol),
        .is_epsilon    (is_epsilon),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .active_states (active_states),
        .status        (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Epsilon closure: keep adding epsilon targets until the set stops growing.
    function automatic logic [31:0] eps_closure(logic [31:0] seed);
        logic [31:0] grown;
        for (int pass = 0; pass < 32; pass++)
        begin
            grown = seed;
            for (int i = 0; i < 32; i++)
                if (seed[i])
                    grown |= eps_edges[i];
            if (grown == seed)
                break;
            seed = grown;
        end
        return seed;
    endfunction

    // Applies one input transaction to the predicted automaton and returns its result.
    function automatic nfa_outcome_t step_automaton(kind_t k, logic [4:0] src, logic [4:0] dst,
                                                    logic [3:0] sym, logic eps);
        nfa_outcome_t res;
        logic [31:0]  reach;
        logic [31:0]  moved;
        res.code = ST_OK;
        case (k)
            KIND_ADD:
            begin
                if (!eps && sym >= cfg_symbols)
                    res.code = ST_BAD_SYMBOL;
                else if (dst >= cfg_states || src >= cfg_states)
                    res.code = ST_NO_STATE;
                else if (eps ? eps_edges[src][dst] : sym_edges[src][sym][dst])
                    res.code = ST_DUPLICATE;
                else if (eps)
                    eps_edges[src][dst] = 1'b1;
                else
                    sym_edges[src][sym][dst] = 1'b1;
            end
            KIND_RESTART:
                live_set = 32'd1 << cfg_start;
            KIND_STEP:
            begin
                if (cfg_symbols == 0)
                    res.code = ST_ALPHA_EMPTY;
                else
                begin
                    // An empty set starts over from the start state.
                    if (live_set == 0)
                        live_set = 32'd1 << cfg_start;
                    reach = eps_closure(live_set);
                    moved = '0;
                    for (int i = 0; i < 32; i++)
                        if (reach[i])
                            moved |= sym_edges[i][sym];
                    live_set = eps_closure(moved);
                end
            end
            default: ;
        endcase
        res.accepted = |(live_set & cfg_accept);
        res.states = live_set;
        return res;
    endfunction

    task automatic note_error(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch on %s: expected 0x%08h, got 0x%08h at %0t ns", what, want, got,
                     $time);
    endtask

    // Sends one input transaction, with random idle cycles ahead of it.
    task automatic send_item(kind_t k, logic [4:0] src, logic [4:0] dst, logic [3:0] sym,
                             logic eps);
        while (idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        from_state <= src;
        to_state <= dst;
        symbol <= sym;
        is_epsilon <= eps;
        do
            @(posedge clk);
        while (in_stall);
        expected_outcomes.push_back(step_automaton(k, src, dst, sym, eps));
        if (k == KIND_ADD)
            adds_sent++;
        else if (k == KIND_STEP)
            steps_sent++;
        else
            others_sent++;
    endtask

    // Holds the sender until every predicted result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Writes all four registers back to back while the engine is idle.
    task automatic configure(logic [4:0] start, logic [5:0] count, logic [4:0] alpha,
                             logic [31:0] mask);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= CFG_START_STATE;
        cfg_data <= 32'(start);
        @(posedge clk);
        cfg_index <= CFG_STATE_COUNT;
        cfg_data <= 32'(count);
        @(posedge clk);
        cfg_index <= CFG_ALPHABET_SIZE;
        cfg_data <= 32'(alpha);
        @(posedge clk);
        cfg_index <= CFG_ACCEPT_MASK;
        cfg_data <= mask;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_start = start;
        cfg_states = count;
        cfg_symbols = alpha;
        cfg_accept = mask;
    endtask

    // Mostly defined states, now and then any index so that missing states show up.
    function automatic logic [4:0] pick_state();
        if ($urandom_range(9) == 0)
            return 5'($urandom_range(31));
        return 5'($urandom_range(int'(cfg_states) - 1));
    endfunction

    function automatic logic [3:0] pick_symbol();
        if (cfg_symbols != 0 && $urandom_range(9) != 0)
            return 4'($urandom_range(int'(cfg_symbols) - 1));
        return 4'($urandom_range(15));
    endfunction

    // Random mix: adds build the automaton, steps walk it, restarts and ignored kinds mixed in.
    task automatic run_random_mix(int count);
        int    pick;
        kind_t k;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
                k = KIND_ADD;
            else if (pick < 30)
                k = KIND_RESTART;
            else if (pick < 34)
                k = KIND_IGNORE;
            else
                k = KIND_STEP;
            send_item(k, pick_state(), pick_state(), pick_symbol(), $urandom_range(99) < 4);
            if ($urandom_range(149) == 0)
                drain_results();
        end
    endtask

    // An empty set with reset registers: steps restart, restart and ignored kinds report.
    task automatic test_after_reset();
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd0, 1'b0);
        send_item(KIND_RESTART, 5'd31, 5'd31, 4'd15, 1'b1);
        send_item(KIND_IGNORE, 5'd17, 5'd9, 4'd10, 1'b1);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd15, 1'b0);
    endtask

    // Add checks in order: symbol first, then target and source states, then duplicates.
    task automatic test_add_checks();
        configure(5'd3, 6'd8, 5'd4, 32'h0000_0010);
        send_item(KIND_ADD, 5'd3, 5'd4, 4'd4, 1'b0);
        send_item(KIND_ADD, 5'd3, 5'd4, 4'd15, 1'b1);
        send_item(KIND_ADD, 5'd3, 5'd8, 4'd1, 1'b0);
        send_item(KIND_ADD, 5'd31, 5'd2, 4'd1, 1'b0);
        send_item(KIND_ADD, 5'd31, 5'd31, 4'd9, 1'b0);
        send_item(KIND_ADD, 5'd3, 5'd4, 4'd3, 1'b0);
        send_item(KIND_ADD, 5'd3, 5'd4, 4'd3, 1'b0);
        send_item(KIND_ADD, 5'd3, 5'd4, 4'd0, 1'b1);
    endtask

    // Steps through closure and move, a symbol outside the alphabet, and an empty alphabet.
    task automatic test_step_cases();
        send_item(KIND_RESTART, 5'd0, 5'd0, 4'd0, 1'b0);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd3, 1'b0);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd15, 1'b0);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd3, 1'b0);
        configure(5'd3, 6'd8, 5'd0, 32'h0000_0008);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd3, 1'b0);
        send_item(KIND_ADD, 5'd1, 5'd2, 4'd0, 1'b0);
    endtask

    // Register extremes: last start state, all accepting, single state and single symbol.
    task automatic test_register_extremes();
        configure(5'd31, 6'd32, 5'd16, 32'hFFFF_FFFF);
        send_item(KIND_RESTART, 5'd0, 5'd0, 4'd0, 1'b0);
        send_item(KIND_ADD, 5'd31, 5'd0, 4'd15, 1'b0);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd15, 1'b0);
        configure(5'd0, 6'd1, 5'd1, 32'h0000_0000);
        send_item(KIND_ADD, 5'd0, 5'd0, 4'd0, 1'b0);
        send_item(KIND_ADD, 5'd0, 5'd1, 4'd0, 1'b0);
        send_item(KIND_STEP, 5'd0, 5'd0, 4'd0, 1'b0);
    endtask

    task automatic test_random_wide();
        configure(5'($urandom_range(31)), 6'd32, 5'd16, $urandom());
        run_random_mix(600);
    endtask

    task automatic test_random_narrow();
        configure(5'($urandom_range(7)), 6'd8, 5'd4, $urandom());
        run_random_mix(500);
    endtask

    // No idling on either side for a long stretch.
    task automatic test_back_to_back();
        configure(5'($urandom_range(19)), 6'd20, 5'd10, $urandom());
        idle_on = 1'b0;
        run_random_mix(400);
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            configure(5'($urandom_range(31)), 6'($urandom_range(32, 1)),
                      5'($urandom_range(16)), $urandom());
            run_random_mix(75);
        end
    endtask

    // A full epsilon chain gives the deepest closures the engine can see.
    task automatic test_deep_chain();
        configure(5'd0, 6'd32, 5'd16, 32'h8000_0000);
        for (int i = 0; i < 31; i++)
            send_item(KIND_ADD, 5'(i), 5'(i + 1), 4'($urandom_range(15)), 1'b1);
        send_item(KIND_RESTART, 5'd0, 5'd0, 4'd0, 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(KIND_STEP, pick_state(), pick_state(), 4'($urandom_range(15)), 1'b0);
    endtask

    // Random stall on the result side.
    always @(posedge clk)
        out_stall <= idle_on ? ($urandom_range(99) < 25) : 1'b0;

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        nfa_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_outcomes.size() == 0)
                note_error("unexpected result", '0, active_states);
            else
            begin
                want = expected_outcomes.pop_front();
                if (accepted !== want.accepted)
                    note_error("accepted", 32'(want.accepted), 32'(accepted));
                if (active_states !== want.states)
                    note_error("active_states", want.states, active_states);
                if (status !== want.code)
                    note_error("status", 32'(want.code), 32'(status));
            end
        end
    end

    initial
    begin
        for (int s = 0; s < 32; s++)
        begin
            eps_edges[s] = '0;
            for (int y = 0; y < 16; y++)
                sym_edges[s][y] = '0;
        end
        live_set = '0;
        cfg_start = 5'd0;
        cfg_states = 6'd32;
        cfg_symbols = 5'd16;
        cfg_accept = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Let the clearing pass finish before any register write.
        while (in_stall !== 1'b0)
            @(posedge clk);

        test_after_reset();
        test_add_checks();
        test_step_cases();
        test_register_extremes();
        test_random_wide();
        test_random_narrow();
        test_back_to_back();
        test_random_settings();
        test_deep_chain();

        drain_results();
        repeat (200) @(posedge clk);

        $display("Sent %0d transactions: %0d adds, %0d symbol steps, %0d restarts or ignored.",
                 adds_sent + steps_sent + others_sent, adds_sent, steps_sent, others_sent);
        $display("Checked %0d results against the predicted automaton; %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still pending.", expected_outcomes.size());
        $display("FAIL");
        $finish;
    end

endmodule
